@@ hdl/sle_pkg.sv @@
// sle_pkg: shared types and constants of the serial line editor
// no dependencies; used by sle_line_ram, serial_line_editor and its checker
package sle_pkg;

  // default line buffer depth
  localparam int unsigned LINE_CAPACITY_DEF = 64;

  // field widths fixed by the interface
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned LEN_W   = 6;

  // configuration port
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam logic        REG_ECHO_ENABLE = 1'b0;  // register select, paddr[2]

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE   = 2'd0,
    CMD_READ_CHAR = 2'd1,
    CMD_RELEASE   = 2'd2
  } cmd_e;

  // terminal control characters
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

endpackage

@@ hdl/serial_line_editor.sv @@
// serial_line_editor: top level, line editing state, echo sequencer, config register
// depends on sle_pkg and sle_line_ram
//
// usage
// - request channel (in_valid_i / in_stall_o) carries cmd_i, rx_data_i and read_index_i;
//   a request is taken at a clock edge with in_valid_i high and in_stall_o low
// - result channel (out_valid_o / out_stall_i) carries the echo byte, last_o and the
//   line status after the request; read_char_o holds the stored byte for a read
// - a received byte gives one to three results when echo is on (the echo sequence),
//   every other request gives exactly one result; last_o marks the final one
// - latency: first result is valid the cycle after the request is taken
// - throughput: one result per cycle unless the receiver stalls; a request is taken
//   in the same cycle as the final result of the previous one, so the cost of a
//   request is set by its echo sequence length through the single output register
// - the line state is updated when the request is taken; the store is an on-chip
//   ram with a registered read, written by ordinary bytes and read by read requests
// - when the receiver stalls, the pending result holds and in_stall_o stays high
// - reset clears length, ready and overflow flags, echo_enable and the result valid;
//   the store needs no clearing since reads stop at the line length
// - echo_enable (apb address 0) should only be written while the block is idle
module serial_line_editor #(
  parameter int unsigned LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sle_pkg::CMD_W-1:0]     cmd_i,
  input  logic [sle_pkg::BYTE_W-1:0]    rx_data_i,
  input  logic [sle_pkg::INDEX_W-1:0]   read_index_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          echo_valid_o,
  output logic [sle_pkg::BYTE_W-1:0]    echo_char_o,
  output logic                          last_o,
  output logic                          ready_flag_o,
  output logic                          overflow_flag_o,
  output logic [sle_pkg::LEN_W-1:0]     length_now_o,
  output logic [sle_pkg::BYTE_W-1:0]    read_char_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sle_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sle_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sle_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import sle_pkg::*;

  // count is at most LINE_CAPACITY-1, so clog2 bits hold it and also address the store
  localparam int unsigned CNT_W = $clog2(LINE_CAPACITY);
  // common width for comparing the read index against the count
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_CAPACITY - 1);

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic echo_en_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_en_q <= 1'b0;
    end else if (cfg_wr && (paddr[2] == REG_ECHO_ENABLE)) begin
      echo_en_q <= pwdata[0];
    end
  end

  // low address bits are byte lanes within the word
  assign prdata = (paddr[2] == REG_ECHO_ENABLE) ? APB_DATA_W'(echo_en_q) : '0;

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  logic             out_valid_q;
  logic [1:0]       left_q;       // results still to follow the one shown
  logic             in_acc;
  logic             out_acc;

  assign out_acc    = out_valid_q && !out_stall_i;
  // a new request may enter while the final result of the previous one leaves
  assign in_stall_o = out_valid_q && (out_stall_i || (left_q != 2'd0));
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // line state and next-state logic
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic              long_q, long_d;

  logic [1:0]        n_echo;      // length of echo sequence, 0 when nothing echoed
  logic [BYTE_W-1:0] seq0, seq1, seq2;
  logic              wr_en;
  logic              rd_ok_d;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  cnt_d_ext;

  assign idx_ext   = CMP_W'(read_index_i);
  assign cnt_ext   = CMP_W'(cnt_q);
  assign cnt_d_ext = CMP_W'(cnt_d);

  always_comb begin
    cnt_d   = cnt_q;
    done_d  = done_q;
    long_d  = long_q;
    n_echo  = 2'd0;
    seq0    = CHAR_NUL;
    seq1    = CHAR_NUL;
    seq2    = CHAR_NUL;
    wr_en   = 1'b0;
    rd_ok_d = 1'b0;
    unique case (cmd_e'(cmd_i))
      CMD_RX_BYTE: begin
        // bytes are dropped while a finished line waits
        if (!done_q) begin
          case (rx_data_i) inside
            CHAR_CR, CHAR_LF: begin
              // empty terminator is ignored
              if ((cnt_q != '0) || long_q) begin
                done_d = 1'b1;
                n_echo = 2'd2;
                seq0   = CHAR_CR;
                seq1   = CHAR_LF;
              end
            end
            CHAR_BS, CHAR_DEL: begin
              if (long_q || (cnt_q != '0)) begin
                // overflow is cleared first, then characters
                if (long_q) begin
                  long_d = 1'b0;
                end else begin
                  cnt_d = CNT_W'(cnt_q - 1'b1);
                end
                n_echo = 2'd3;
                seq0   = CHAR_BS;
                seq1   = CHAR_SPACE;
                seq2   = CHAR_BS;
              end
            end
            default: begin
              if (cnt_q < CNT_LIMIT) begin
                wr_en  = 1'b1;
                cnt_d  = CNT_W'(cnt_q + 1'b1);
                n_echo = 2'd1;
                seq0   = rx_data_i;
              end else begin
                long_d = 1'b1;
              end
            end
          endcase
        end
      end
      CMD_READ_CHAR: begin
        // count never exceeds capacity-1, so this also bounds the store address
        rd_ok_d = idx_ext < cnt_ext;
      end
      CMD_RELEASE: begin
        if (done_q) begin
          cnt_d  = '0;
          done_d = 1'b0;
          long_d = 1'b0;
        end
      end
      default: begin
        // unused command reports status only
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      long_q <= 1'b0;
    end else if (in_acc) begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
      long_q <= long_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line store
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] rd_data;

  sle_line_ram #(
    .DEPTH  (LINE_CAPACITY),
    .ADDR_W (CNT_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && wr_en),
    .waddr_i (cnt_q),
    .wdata_i (rx_data_i),
    .re_i    (in_acc),
    .raddr_i (idx_ext[CNT_W-1:0]),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // result register and echo sequencer
  // ---------------------------------------------------------------------------
  logic              echo_valid_q;
  logic [BYTE_W-1:0] echo_char_q;
  logic [BYTE_W-1:0] buf1_q, buf2_q;
  logic              ready_q, ovf_q;
  logic [LEN_W-1:0]  len_q;
  logic              rd_ok_q;
  logic              echo_on;

  // with echo off or nothing to echo, a single silent result
  assign echo_on = echo_en_q && (n_echo != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q      <= 2'd0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
      left_q      <= echo_on ? 2'(n_echo - 2'd1) : 2'd0;
    end else if (out_acc) begin
      if (left_q != 2'd0) begin
        left_q <= 2'(left_q - 2'd1);
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      echo_valid_q <= echo_on;
      echo_char_q  <= echo_on ? seq0 : CHAR_NUL;
      buf1_q       <= seq1;
      buf2_q       <= seq2;
      ready_q      <= done_d;
      ovf_q        <= long_d;
      len_q        <= cnt_d_ext[LEN_W-1:0];
      rd_ok_q      <= rd_ok_d;
    end else if (out_acc && (left_q != 2'd0)) begin
      // next byte of the echo sequence
      echo_char_q <= buf1_q;
      buf1_q      <= buf2_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign echo_valid_o    = echo_valid_q;
  assign echo_char_o     = echo_char_q;
  assign last_o          = (left_q == 2'd0);
  assign ready_flag_o    = ready_q;
  assign overflow_flag_o = ovf_q;
  assign length_now_o    = len_q;
  assign read_char_o     = rd_ok_q ? rd_data : CHAR_NUL;

endmodule

@@ hdl/sle_line_ram.sv @@
// sle_line_ram: line character store, one write port and one registered read port
// depends on sle_pkg
module sle_line_ram #(
  parameter int unsigned DEPTH  = sle_pkg::LINE_CAPACITY_DEF,
  parameter int unsigned ADDR_W = $clog2(sle_pkg::LINE_CAPACITY_DEF)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [sle_pkg::BYTE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic [sle_pkg::BYTE_W-1:0] rdata_o
);
  import sle_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sle_checker.sv @@
// sle_checker: port-level checks of the serial line editor, bound to the top level
// depends on sle_pkg and serial_line_editor
module sle_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic                        echo_valid_o,
  input  logic [sle_pkg::BYTE_W-1:0]  echo_char_o,
  input  logic                        last_o,
  input  logic [sle_pkg::BYTE_W-1:0]  read_char_o
);
  import sle_pkg::*;

  // an echo sequence is never cut short
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("result sequence ended without last");

  // a silent result carries no echo byte
  a_silent_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !echo_valid_o |-> echo_char_o == CHAR_NUL)
    else $error("echo_char set while echo_valid low");

  // echo results never carry read data
  a_echo_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && echo_valid_o |-> read_char_o == CHAR_NUL)
    else $error("read_char set on an echo result");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(echo_char_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule

bind serial_line_editor sle_checker u_sle_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .echo_valid_o (echo_valid_o),
  .echo_char_o  (echo_char_o),
  .last_o       (last_o),
  .read_char_o  (read_char_o)
);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for serial_line_editor, line editing, echo and apb register
// depends on sle_pkg, serial_line_editor and sle_line_ram; needs no other file
module tb_top;
  import sle_pkg::*;

  localparam int unsigned LINE_CAP = sle_pkg::LINE_CAPACITY_DEF;
  // command code that the block has no name for, must be ignored
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // echo_enable is register 0, byte address 0
  localparam logic [APB_ADDR_W-1:0] ECHO_ENABLE_ADDR = {REG_ECHO_ENABLE, 2'b00};

  // one result as the block reports it
  typedef struct {
    logic              echo_valid;
    logic [BYTE_W-1:0] echo_char;
    logic              last;
    logic              ready_flag;
    logic              overflow_flag;
    logic [LEN_W-1:0]  length_now;
    logic [BYTE_W-1:0] read_char;
  } reply_t;

  // clock, reset and every block input start at a known value
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      cmd_i = '0;
  logic [BYTE_W-1:0]     rx_data_i = '0;
  logic [INDEX_W-1:0]    read_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  echo_valid_o;
  logic [BYTE_W-1:0]     echo_char_o;
  logic                  last_o;
  logic                  ready_flag_o;
  logic                  overflow_flag_o;
  logic [LEN_W-1:0]      length_now_o;
  logic [BYTE_W-1:0]     read_char_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow copy of the line state, advanced once per accepted request
  logic [BYTE_W-1:0] line_text [LINE_CAP];
  int unsigned       line_len = 0;
  bit                line_finished = 1'b0;
  bit                line_overflow = 1'b0;
  bit                line_echo = 1'b0;

  // results still owed by the block, oldest first
  reply_t      replies_due[$];
  int unsigned fault_count = 0;
  int unsigned requests_sent = 0;
  // sender burst bookkeeping
  int unsigned burst_left = 0;
  // receiver stall pattern
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;

  serial_line_editor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .rx_data_i       (rx_data_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .echo_valid_o    (echo_valid_o),
    .echo_char_o     (echo_char_o),
    .last_o          (last_o),
    .ready_flag_o    (ready_flag_o),
    .overflow_flag_o (overflow_flag_o),
    .length_now_o    (length_now_o),
    .read_char_o     (read_char_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // queue one owed result built from the shadow state after the request
  function automatic void owe_reply(logic ev, logic [BYTE_W-1:0] ch, logic fin,
                                    logic [BYTE_W-1:0] rd);
    reply_t r;
    r.echo_valid    = ev;
    r.echo_char     = ev ? ch : CHAR_NUL;
    r.last          = fin;
    r.ready_flag    = line_finished;
    r.overflow_flag = line_overflow;
    r.length_now    = LEN_W'(line_len);
    r.read_char     = rd;
    replies_due.push_back(r);
  endfunction

  // line editing rules: update the shadow line and owe the results of one request
  function automatic void apply_to_line(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
                                        logic [INDEX_W-1:0] idx);
    logic [BYTE_W-1:0] seq [3];
    int                n;
    int                k;
    logic [BYTE_W-1:0] rd;
    n  = 0;
    rd = CHAR_NUL;
    case (cmd)
      CMD_RX_BYTE: begin
        // a finished line swallows every byte until it is released
        if (!line_finished) begin
          if (b == CHAR_CR || b == CHAR_LF) begin
            // empty terminator does nothing
            if (line_len != 0 || line_overflow) begin
              line_finished = 1'b1;
              seq[0] = CHAR_CR;
              seq[1] = CHAR_LF;
              n = 2;
            end
          end else if (b == CHAR_BS || b == CHAR_DEL) begin
            // rubout undoes the overflow first, then the last character
            if (line_overflow || line_len != 0) begin
              if (line_overflow) line_overflow = 1'b0;
              else line_len--;
              seq[0] = CHAR_BS;
              seq[1] = CHAR_SPACE;
              seq[2] = CHAR_BS;
              n = 3;
            end
          end else if (line_len < LINE_CAP - 1) begin
            line_text[line_len] = b;
            line_len++;
            seq[0] = b;
            n = 1;
          end else begin
            line_overflow = 1'b1;
          end
        end
      end
      CMD_READ_CHAR: begin
        if (idx < line_len && idx < LINE_CAP) rd = line_text[idx];
      end
      CMD_RELEASE: begin
        if (line_finished) begin
          line_len      = 0;
          line_finished = 1'b0;
          line_overflow = 1'b0;
        end
      end
      default: ;
    endcase
    if (cmd == CMD_RX_BYTE && line_echo && n != 0) begin
      for (k = 0; k < n; k++) owe_reply(1'b1, seq[k], k == n - 1, CHAR_NUL);
    end else begin
      owe_reply(1'b0, CHAR_NUL, 1'b1, rd);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] pick_text_byte();
    return BYTE_W'($urandom_range(8'h20, 8'h7E));
  endfunction

  // drive one request and hold it until taken; bursts of random length
  // with random gaps in between
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                              input logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    rx_data_i    <= data;
    read_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // request taken at this edge
    apply_to_line(cmd, data, idx);
    requests_sent++;
  endtask

  // drop valid and wait until the block owes nothing
  task automatic settle_line();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write of echo_enable, then read it back
  task automatic write_echo_enable(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ECHO_ENABLE_ADDR;
    pwdata  <= {{(APB_DATA_W-1){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    line_echo = value;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[0] !== value) begin
      $error("echo_enable readback: expected %0b, got %0b", value, prdata[0]);
      fault_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver stall pattern: spans of free flow, light stalls and heavy stalls
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_span = $urandom_range(8, 64);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // every taken result is compared with the oldest owed one
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        $error("result with nothing owed: echo_char %h, length_now %0d",
               echo_char_o, length_now_o);
        fault_count++;
      end else begin
        want = replies_due.pop_front();
        if (echo_valid_o !== want.echo_valid) begin
          $error("echo_valid: expected %0b, got %0b", want.echo_valid, echo_valid_o);
          fault_count++;
        end
        if (echo_char_o !== want.echo_char) begin
          $error("echo_char: expected %h, got %h", want.echo_char, echo_char_o);
          fault_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          fault_count++;
        end
        if (ready_flag_o !== want.ready_flag) begin
          $error("ready_flag: expected %0b, got %0b", want.ready_flag, ready_flag_o);
          fault_count++;
        end
        if (overflow_flag_o !== want.overflow_flag) begin
          $error("overflow_flag: expected %0b, got %0b", want.overflow_flag,
                 overflow_flag_o);
          fault_count++;
        end
        if (length_now_o !== want.length_now) begin
          $error("length_now: expected %0d, got %0d", want.length_now, length_now_o);
          fault_count++;
        end
        if (read_char_o !== want.read_char) begin
          $error("read_char: expected %h, got %h", want.read_char, read_char_o);
          fault_count++;
        end
      end
    end
  end

  // requests on an empty line: nothing to release, unused command,
  // rubout on empty line, empty terminators, reads past the end
  task automatic test_idle_commands();
    write_echo_enable(1'b1);
    send_request(CMD_RELEASE, 8'h00, 6'd0);
    send_request(CMD_UNUSED, 8'hFF, 6'd63);
    send_request(CMD_RX_BYTE, CHAR_BS, 6'd0);
    send_request(CMD_RX_BYTE, CHAR_DEL, 6'd0);
    send_request(CMD_RX_BYTE, CHAR_CR, 6'd0);
    send_request(CMD_RX_BYTE, CHAR_LF, 6'd0);
    send_request(CMD_READ_CHAR, 8'h00, 6'd0);
    send_request(CMD_READ_CHAR, 8'h00, 6'd63);
  endtask

  // a short line: byte extremes, rubout, reads, terminator, dropped bytes, release
  task automatic test_line_editing();
    send_request(CMD_RX_BYTE, 8'h00, 6'd0);
    send_request(CMD_RX_BYTE, 8'hFF, 6'd63);
    send_request(CMD_RX_BYTE, 8'h61, 6'd0);
    send_request(CMD_RX_BYTE, CHAR_DEL, 6'd0);
    send_request(CMD_RX_BYTE, 8'h80, 6'd0);
    send_request(CMD_READ_CHAR, 8'h00, 6'd0);
    send_request(CMD_READ_CHAR, 8'h00, 6'd2);
    send_request(CMD_READ_CHAR, 8'h00, 6'd3);
    send_request(CMD_RX_BYTE, CHAR_LF, 6'd0);
    // line finished: further bytes are dropped
    send_request(CMD_RX_BYTE, 8'h78, 6'd0);
    send_request(CMD_RX_BYTE, CHAR_BS, 6'd0);
    send_request(CMD_RX_BYTE, CHAR_CR, 6'd0);
    send_request(CMD_READ_CHAR, 8'h00, 6'd1);
    send_request(CMD_RELEASE, 8'h00, 6'd0);
    send_request(CMD_READ_CHAR, 8'h00, 6'd0);
  endtask

  // fill the line to capacity, overflow it, rub out, refill and finish
  task automatic test_overflow();
    repeat (LINE_CAP - 1) send_request(CMD_RX_BYTE, pick_text_byte(), 6'd0);
    send_request(CMD_RX_BYTE, 8'h41, 6'd0);
    send_request(CMD_RX_BYTE, 8'h42, 6'd0);
    send_request(CMD_RX_BYTE, CHAR_BS, 6'd0);
    send_request(CMD_RX_BYTE, CHAR_DEL, 6'd0);
    send_request(CMD_RX_BYTE, 8'h7E, 6'd0);
    send_request(CMD_RX_BYTE, 8'h43, 6'd0);
    send_request(CMD_RX_BYTE, CHAR_CR, 6'd0);
    send_request(CMD_READ_CHAR, 8'h00, 6'd62);
    send_request(CMD_READ_CHAR, 8'h00, 6'd63);
    send_request(CMD_RELEASE, 8'h00, 6'd0);
  endtask

  // phases of random traffic: mostly whole lines with random text,
  // rubouts, reads and a release, mixed with raw random requests
  task automatic test_random_traffic();
    int unsigned       phase;
    int unsigned       goal;
    int unsigned       text_len;
    logic [BYTE_W-1:0] ch;
    for (phase = 0; phase < 8; phase++) begin
      // the sender pauses here until every owed result has come
      settle_line();
      // first two phases pin both echo settings, the rest pick at random
      write_echo_enable(phase < 2 ? phase[0] : logic'($urandom_range(0, 1)));
      goal = requests_sent + 28;
      while (requests_sent < goal) begin
        if ($urandom_range(0, 9) < 7) begin
          // mostly short lines, now and then a long one that may run past capacity
          text_len = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 70)
                                                 : $urandom_range(1, 8);
          repeat (text_len) begin
            case ($urandom_range(0, 11))
              0:       ch = CHAR_BS;
              1:       ch = CHAR_DEL;
              default: ch = pick_text_byte();
            endcase
            send_request(CMD_RX_BYTE, ch, INDEX_W'($urandom_range(0, 63)));
          end
          send_request(CMD_RX_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF,
                       INDEX_W'($urandom_range(0, 63)));
          repeat ($urandom_range(1, 3))
            send_request(CMD_READ_CHAR, BYTE_W'($urandom_range(0, 255)),
                         INDEX_W'($urandom_range(0, text_len < 63 ? text_len : 63)));
          send_request(CMD_RELEASE, BYTE_W'($urandom_range(0, 255)),
                       INDEX_W'($urandom_range(0, 63)));
        end else begin
          send_request(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                       INDEX_W'($urandom_range(0, 63)));
        end
      end
    end
  endtask

  initial begin
    // reset held low from the start, then released once
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_commands();
    test_line_editing();
    test_overflow();
    test_random_traffic();
    // drain, then let the clock run on before the verdict
    settle_line();
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/sle_pkg.sv
hdl/sle_line_ram.sv
hdl/serial_line_editor.sv
hdl/sle_checker.sv
tb/tb_top.sv
